// File: src/efi_pkg.sv
// efi_pkg: shared constants, codes and structs of the escape-time fractal iterator.
// Used by efi_mul, efi_dp, efi_ctrl and escape_time_fractal_iterator; no dependencies.
`default_nettype none

package efi_pkg;

   // Fixed field widths
   localparam int PIX_W   = 16;
   localparam int ITER_W  = 16;
   localparam int MAG_W   = 63;
   localparam int WORD_W  = 64;
   localparam int CSR_IDX_W = 3;

   // Number format and tuning
   localparam int COORD_WIDTH  = 16;
   localparam int FRAC_BITS    = 56;
   localparam int ESCAPE_BOUND = 4;
   localparam int BOUND_WHOLE  = 4;

   localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

   localparam logic signed [63:0] BOUND_MANDEL_Q =
      (64'(ESCAPE_BOUND) > (64'h7FFF_FFFF_FFFF_FFFF >> FRAC_BITS)) ?
      Q_MAX : (64'(ESCAPE_BOUND) << FRAC_BITS);
   localparam logic signed [63:0] BOUND_OTHER_Q =
      (64'(BOUND_WHOLE) > (64'h7FFF_FFFF_FFFF_FFFF >> FRAC_BITS)) ?
      Q_MAX : (64'(BOUND_WHOLE) << FRAC_BITS);

   // Periodicity tolerance, 0.00001 rounded to the nearest LSB
   localparam logic signed [63:0] TOL_Q =
      ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
   localparam logic signed [63:0] NEG_TOL_Q = -TOL_Q;

   // Reference point is refreshed once the period counter reaches this value
   localparam int PERIOD_W = 5;
   localparam logic [PERIOD_W-1:0] PERIOD_LAST = PERIOD_W'(20);

   // Shared multiplier: 64x64 magnitude product from four 32x32 partials
   localparam int PROD_W    = 128;
   localparam int HALF_W    = 32;
   localparam int MUL_CNT_W = 3;
   localparam logic [MUL_CNT_W-1:0] MUL_PARTS = MUL_CNT_W'(4);

   // Width of pixel*scale+offset before saturation
   localparam int MAP_W = COORD_WIDTH + WORD_W + 2;

   localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(64);

   typedef enum logic [1:0] {
      KIND_MANDEL  = 2'd0,
      KIND_JULIA   = 2'd1,
      KIND_TRICORN = 2'd2,
      KIND_SHIP    = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KIND     = 3'd0,
      CSR_SCALE_X  = 3'd1,
      CSR_SCALE_Y  = 3'd2,
      CSR_OFFSET_X = 3'd3,
      CSR_OFFSET_Y = 3'd4,
      CSR_JULIA_RE = 3'd5,
      CSR_JULIA_IM = 3'd6,
      CSR_MAX_ITER = 3'd7
   } csr_idx_type;

   // Which product the shared multiplier forms
   typedef enum logic [2:0] {
      OP_MAPX = 3'd0,
      OP_MAPY = 3'd1,
      OP_XX   = 3'd2,
      OP_YY   = 3'd3,
      OP_XY   = 3'd4
   } op_type;

   typedef struct packed {
      kind_type           fractal_kind;
      logic signed [63:0] scale_x;
      logic signed [63:0] scale_y;
      logic signed [63:0] offset_x;
      logic signed [63:0] offset_y;
      logic signed [63:0] julia_re;
      logic signed [63:0] julia_im;
      logic [ITER_W-1:0]  max_iterations;
   } cfg_type;

   typedef struct packed {
      logic   load_item;
      logic   mul_start;
      op_type mul_op;
      logic   upd1;
      logic   upd2;
      logic   upd3;
      logic   chk1;
      logic   period_step;
      logic   set_periodic;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic go_on;
      logic close;
   } status_type;

endpackage

`default_nettype wire

// File: src/efi_mul.sv
// efi_mul: sequential 64x64 magnitude multiplier built on one 32x32 multiplier.
// Depends on efi_pkg.
`default_nettype none

module efi_mul (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [efi_pkg::WORD_W-1:0]  op_a,
   input  wire logic [efi_pkg::WORD_W-1:0]  op_b,
   output logic      [efi_pkg::PROD_W-1:0]  prod,
   output logic                             neg,
   output logic                             done
);
   import efi_pkg::*;

   logic [WORD_W-1:0]    ua_ff, ua_in, ub_ff, ub_in;
   logic                 neg_ff, neg_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    pp_ff, pp_in;
   logic [1:0]           pp_idx_ff, pp_idx_in;
   logic                 pp_vld_ff, pp_vld_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [HALF_W-1:0]    ma, mb;
   logic [WORD_W-1:0]    pp_prod;
   logic [PROD_W-1:0]    addend;

   // Partial order: lo*lo, lo*hi, hi*lo, hi*hi
   assign ma      = cnt_ff[1] ? ua_ff[WORD_W-1:HALF_W] : ua_ff[HALF_W-1:0];
   assign mb      = cnt_ff[0] ? ub_ff[WORD_W-1:HALF_W] : ub_ff[HALF_W-1:0];
   assign pp_prod = ma * mb;

   always_comb begin
      case (pp_idx_ff) inside
         2'd0:       addend = {64'd0, pp_ff};
         2'd1, 2'd2: addend = {32'd0, pp_ff, 32'd0};
         default:    addend = {pp_ff, 64'd0};
      endcase
   end

   always_comb begin
      ua_in     = ua_ff;
      ub_in     = ub_ff;
      neg_in    = neg_ff;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      pp_in     = pp_ff;
      pp_idx_in = pp_idx_ff;
      pp_vld_in = pp_vld_ff;
      acc_in    = acc_ff;
      done_in   = 1'b0;
      if (busy_ff) begin
         if (pp_vld_ff) begin
            acc_in = acc_ff + addend;
         end
         if (cnt_ff < MUL_PARTS) begin
            pp_in     = pp_prod;
            pp_idx_in = cnt_ff[1:0];
            pp_vld_in = 1'b1;
            cnt_in    = cnt_ff + MUL_CNT_W'(1);
         end else begin
            pp_vld_in = 1'b0;
            busy_in   = 1'b0;
            done_in   = 1'b1;
         end
      end else if (start) begin
         ua_in     = op_a[WORD_W-1] ? (~op_a + WORD_W'(1)) : op_a;
         ub_in     = op_b[WORD_W-1] ? (~op_b + WORD_W'(1)) : op_b;
         neg_in    = op_a[WORD_W-1] ^ op_b[WORD_W-1];
         cnt_in    = '0;
         acc_in    = '0;
         pp_vld_in = 1'b0;
         busy_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         pp_vld_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         pp_vld_ff <= pp_vld_in;
         cnt_ff    <= cnt_in;
      end
      ua_ff     <= ua_in;
      ub_ff     <= ub_in;
      neg_ff    <= neg_in;
      pp_ff     <= pp_in;
      pp_idx_ff <= pp_idx_in;
      acc_ff    <= acc_in;
   end

   assign prod = acc_ff;
   assign neg  = neg_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// File: src/efi_dp.sv
// efi_dp: datapath of the iterator: point registers, saturating arithmetic, period check.
// Depends on efi_pkg and efi_mul.
`default_nettype none

module efi_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire efi_pkg::cmd_type                  cmd,
   output efi_pkg::status_type                    status,
   input  wire efi_pkg::cfg_type                  cfg,
   input  wire logic [efi_pkg::PIX_W-1:0]         req_pixel_x,
   input  wire logic [efi_pkg::PIX_W-1:0]         req_pixel_y,
   output logic      [efi_pkg::ITER_W-1:0]        rsp_iterations,
   output logic      [efi_pkg::MAG_W-1:0]         rsp_final_magnitude_sq
);
   import efi_pkg::*;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? Q_MIN : Q_MAX;
      return s;
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) return a[63] ? Q_MIN : Q_MAX;
      return s;
   endfunction

   function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
      return (a == Q_MIN) ? Q_MAX : -a;
   endfunction

   function automatic logic signed [63:0] sat_abs(input logic signed [63:0] a);
      return a[63] ? sat_neg(a) : a;
   endfunction

   // Floor of the magnitude product over 2^FRAC_BITS, signed and saturated.
   function automatic logic signed [63:0] q_finish(input logic [PROD_W-1:0] p,
                                                   input logic neg);
      logic [63:0] qlo;
      logic        hi_nz;
      logic        rem;
      qlo   = p[FRAC_BITS +: 64];
      hi_nz = |p[PROD_W-1:FRAC_BITS+64];
      rem   = |p[FRAC_BITS-1:0];
      if (hi_nz || qlo[63]) return neg ? Q_MIN : Q_MAX;
      if (!neg) return signed'(qlo);
      // -(qlo + rem): ~qlo when a remainder rounds down, else the plain negate
      return signed'(~qlo + {63'd0, !rem});
   endfunction

   function automatic logic signed [63:0] map_finish(input logic [PROD_W-1:0] p,
                                                     input logic neg,
                                                     input logic signed [63:0] off);
      logic [MAP_W-1:0] pe;
      logic [MAP_W-1:0] oe;
      logic [MAP_W-1:0] v;
      pe = p[MAP_W-1:0];
      oe = {{(MAP_W-64){off[63]}}, off};
      v  = neg ? (oe - pe) : (oe + pe);
      if (v[MAP_W-1] && !(&v[MAP_W-1:63])) return Q_MIN;
      if (!v[MAP_W-1] && (|v[MAP_W-1:63])) return Q_MAX;
      return signed'(v[63:0]);
   endfunction

   logic [COORD_WIDTH-1:0] pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic signed [63:0]     x_ff, x_in, y_ff, y_in, ka_ff, ka_in, kb_ff, kb_in;
   logic signed [63:0]     x2_ff, x2_in, y2_ff, y2_in, t_ff, t_in;
   logic signed [63:0]     d_ff, d_in, tn_ff, tn_in, dx_ff, dx_in, dy_ff, dy_in;
   logic signed [63:0]     refx_ff, refx_in, refy_ff, refy_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;
   logic [ITER_W-1:0]      it_ff, it_in;
   logic [ITER_W-1:0]      rsp_it_ff, rsp_it_in;
   logic [MAG_W-1:0]       rsp_mag_ff, rsp_mag_in;

   logic [WORD_W-1:0]      mul_a, mul_b;
   logic [PROD_W-1:0]      mul_prod;
   logic                   mul_neg, mul_done;
   logic signed [63:0]     q_r, map_r, map_off, dbl, mag_sum, bound;

   efi_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod),
      .neg   (mul_neg),
      .done  (mul_done)
   );

   always_comb begin
      unique case (cmd.mul_op)
         OP_MAPX: begin
            mul_a = {{(WORD_W-COORD_WIDTH){1'b0}}, pix_x_ff};
            mul_b = cfg.scale_x;
         end
         OP_MAPY: begin
            mul_a = {{(WORD_W-COORD_WIDTH){1'b0}}, pix_y_ff};
            mul_b = cfg.scale_y;
         end
         OP_XX: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         OP_YY: begin
            mul_a = y_ff;
            mul_b = y_ff;
         end
         default: begin
            mul_a = x_ff;
            mul_b = y_ff;
         end
      endcase
   end

   assign map_off = (cmd.mul_op == OP_MAPY) ? cfg.offset_y : cfg.offset_x;
   assign q_r     = q_finish(mul_prod, mul_neg);
   assign map_r   = map_finish(mul_prod, mul_neg, map_off);
   assign mag_sum = sat_add(x2_ff, y2_ff);
   assign bound   = (cfg.fractal_kind == KIND_MANDEL) ? BOUND_MANDEL_Q : BOUND_OTHER_Q;

   // 2xy with saturation: a doubling overflows when the top two bits differ
   assign dbl = (t_ff[63] != t_ff[62]) ? (t_ff[63] ? Q_MIN : Q_MAX) : (t_ff <<< 1);

   always_comb begin
      pix_x_in   = pix_x_ff;
      pix_y_in   = pix_y_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      ka_in      = ka_ff;
      kb_in      = kb_ff;
      x2_in      = x2_ff;
      y2_in      = y2_ff;
      t_in       = t_ff;
      d_in       = d_ff;
      tn_in      = tn_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      refx_in    = refx_ff;
      refy_in    = refy_ff;
      period_in  = period_ff;
      it_in      = it_ff;
      rsp_it_in  = rsp_it_ff;
      rsp_mag_in = rsp_mag_ff;

      if (cmd.load_item) begin
         pix_x_in  = req_pixel_x[COORD_WIDTH-1:0];
         pix_y_in  = req_pixel_y[COORD_WIDTH-1:0];
         it_in     = '0;
         period_in = '0;
         refx_in   = '0;
         refy_in   = '0;
      end

      if (mul_done) begin
         unique case (cmd.mul_op)
            OP_MAPX: begin
               x_in  = (cfg.fractal_kind == KIND_MANDEL) ? '0 : map_r;
               ka_in = (cfg.fractal_kind == KIND_JULIA) ? cfg.julia_re : map_r;
            end
            OP_MAPY: begin
               y_in  = (cfg.fractal_kind == KIND_MANDEL) ? '0 : map_r;
               kb_in = (cfg.fractal_kind == KIND_JULIA) ? cfg.julia_im : map_r;
            end
            OP_XX:   x2_in = q_r;
            OP_YY:   y2_in = q_r;
            OP_XY:   t_in  = q_r;
            default: ;
         endcase
      end

      if (cmd.upd1) begin
         d_in  = sat_sub(x2_ff, y2_ff);
         tn_in = (cfg.fractal_kind == KIND_TRICORN) ? sat_neg(dbl) : dbl;
      end

      if (cmd.upd2) begin
         x_in = sat_add(d_ff, ka_ff);
         y_in = sat_add(tn_ff, kb_ff);
      end

      if (cmd.upd3) begin
         if (cfg.fractal_kind == KIND_SHIP) begin
            x_in = sat_abs(x_ff);
            y_in = sat_abs(y_ff);
         end
         it_in = it_ff + ITER_W'(1);
      end

      if (cmd.chk1) begin
         dx_in = sat_sub(x_ff, refx_ff);
         dy_in = sat_sub(y_ff, refy_ff);
      end

      if (cmd.period_step) begin
         if (period_ff == PERIOD_LAST) begin
            period_in = '0;
            refx_in   = x_ff;
            refy_in   = y_ff;
         end else begin
            period_in = period_ff + PERIOD_W'(1);
         end
      end

      if (cmd.set_periodic) begin
         it_in = cfg.max_iterations;
      end

      if (cmd.out_load) begin
         rsp_it_in  = it_ff;
         rsp_mag_in = mag_sum[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      pix_x_ff   <= pix_x_in;
      pix_y_ff   <= pix_y_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      ka_ff      <= ka_in;
      kb_ff      <= kb_in;
      x2_ff      <= x2_in;
      y2_ff      <= y2_in;
      t_ff       <= t_in;
      d_ff       <= d_in;
      tn_ff      <= tn_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      refx_ff    <= refx_in;
      refy_ff    <= refy_in;
      period_ff  <= period_in;
      it_ff      <= it_in;
      rsp_it_ff  <= rsp_it_in;
      rsp_mag_ff <= rsp_mag_in;
   end

   assign status.mul_done = mul_done;
   assign status.go_on    = (mag_sum <= bound) && (it_ff < cfg.max_iterations);
   assign status.close    = (dx_ff > NEG_TOL_Q) && (dx_ff < TOL_Q) &&
                            (dy_ff > NEG_TOL_Q) && (dy_ff < TOL_Q);

   assign rsp_iterations         = rsp_it_ff;
   assign rsp_final_magnitude_sq = rsp_mag_ff;

endmodule

`default_nettype wire

// File: src/efi_ctrl.sv
// efi_ctrl: sequencer of the iterator; issues datapath commands and owns the handshakes.
// Depends on efi_pkg.
`default_nettype none

module efi_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire efi_pkg::kind_type     fractal_kind,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output efi_pkg::cmd_type           cmd,
   input  wire efi_pkg::status_type   status
);
   import efi_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_MAPX = 13'b0000000000010,
      ST_MAPY = 13'b0000000000100,
      ST_SQX  = 13'b0000000001000,
      ST_SQY  = 13'b0000000010000,
      ST_TEST = 13'b0000000100000,
      ST_PROD = 13'b0000001000000,
      ST_UPD1 = 13'b0000010000000,
      ST_UPD2 = 13'b0000100000000,
      ST_UPD3 = 13'b0001000000000,
      ST_CHK1 = 13'b0010000000000,
      ST_CHK2 = 13'b0100000000000,
      ST_DONE = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      launched_ff, launched_in;
   logic      iter_ff, iter_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      check_en;
   logic      mul_state;

   assign check_en  = (fractal_kind != KIND_JULIA);
   assign mul_state = (state_ff == ST_MAPX) || (state_ff == ST_MAPY) ||
                      (state_ff == ST_SQX)  || (state_ff == ST_SQY)  ||
                      (state_ff == ST_PROD);

   always_comb begin
      state_in    = state_ff;
      iter_in     = iter_ff;
      launched_in = launched_ff;
      cmd         = '0;
      cmd.mul_op  = OP_XY;

      // one launch per product; cleared on the done pulse
      if (mul_state) begin
         cmd.mul_start = !launched_ff;
         launched_in   = !status.mul_done;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               iter_in       = 1'b0;
               state_in      = ST_MAPX;
            end
         end
         ST_MAPX: begin
            cmd.mul_op = OP_MAPX;
            if (status.mul_done) state_in = ST_MAPY;
         end
         ST_MAPY: begin
            cmd.mul_op = OP_MAPY;
            if (status.mul_done) state_in = ST_SQX;
         end
         ST_SQX: begin
            cmd.mul_op = OP_XX;
            if (status.mul_done) state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.mul_op = OP_YY;
            if (status.mul_done) state_in = (iter_ff && check_en) ? ST_CHK1 : ST_TEST;
         end
         ST_TEST: begin
            state_in = status.go_on ? ST_PROD : ST_DONE;
         end
         ST_PROD: begin
            cmd.mul_op = OP_XY;
            if (status.mul_done) state_in = ST_UPD1;
         end
         ST_UPD1: begin
            cmd.upd1 = 1'b1;
            state_in = ST_UPD2;
         end
         ST_UPD2: begin
            cmd.upd2 = 1'b1;
            state_in = ST_UPD3;
         end
         ST_UPD3: begin
            cmd.upd3 = 1'b1;
            iter_in  = 1'b1;
            state_in = ST_SQX;
         end
         ST_CHK1: begin
            cmd.chk1 = 1'b1;
            state_in = ST_CHK2;
         end
         ST_CHK2: begin
            if (status.close) begin
               cmd.set_periodic = 1'b1;
               state_in         = ST_DONE;
            end else begin
               cmd.period_step = 1'b1;
               state_in        = ST_TEST;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         iter_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: src/escape_time_fractal_iterator.sv
// escape_time_fractal_iterator: top level; register bank, sequencer and datapath.
// Depends on efi_pkg, efi_ctrl, efi_dp (and efi_mul below it).
//
// Usage:
//  - req channel: one item is a pixel (req_pixel_x, req_pixel_y). It is mapped to
//    c = pixel * scale + offset per axis in signed Q8.56 and iterated for the
//    kind in fractal_kind until the squared magnitude leaves the bound, the
//    count reaches max_iterations, or (all kinds but julia) the orbit comes back
//    within 0.00001 of its saved reference point.
//  - rsp channel: one item per request: iteration count and saturated |z|^2.
//  - csr channel: register index plus 64-bit data, always ready; write only
//    while no item is in flight.
//  - Items are processed one at a time. All 64-bit products share one 32x32
//    multiplier, three products per iteration.
//  - req_ready is high while the sequencer is idle, also while a finished item
//    still sits in the output register. A stalled receiver holds the next
//    result in the sequencer until the output register frees up.
//  - Reset (synchronous, active high) empties the block and restores the
//    registers: kind mandelbrot, all Q8.56 values zero, max_iterations 64.
`default_nettype none

module escape_time_fractal_iterator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [efi_pkg::PIX_W-1:0]        req_pixel_x,
   input  wire logic [efi_pkg::PIX_W-1:0]        req_pixel_y,
   // response
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [efi_pkg::ITER_W-1:0]       rsp_iterations,
   output logic      [efi_pkg::MAG_W-1:0]        rsp_final_magnitude_sq,
   // register writes
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [efi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [efi_pkg::WORD_W-1:0]       csr_data
);
   import efi_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   // register bank
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_KIND:     cfg_in.fractal_kind   = kind_type'(csr_data[1:0]);
            CSR_SCALE_X:  cfg_in.scale_x        = csr_data;
            CSR_SCALE_Y:  cfg_in.scale_y        = csr_data;
            CSR_OFFSET_X: cfg_in.offset_x       = csr_data;
            CSR_OFFSET_Y: cfg_in.offset_y       = csr_data;
            CSR_JULIA_RE: cfg_in.julia_re       = csr_data;
            CSR_JULIA_IM: cfg_in.julia_im       = csr_data;
            CSR_MAX_ITER: cfg_in.max_iterations = csr_data[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fractal_kind   <= KIND_MANDEL;
         cfg_ff.scale_x        <= '0;
         cfg_ff.scale_y        <= '0;
         cfg_ff.offset_x       <= '0;
         cfg_ff.offset_y       <= '0;
         cfg_ff.julia_re       <= '0;
         cfg_ff.julia_im       <= '0;
         cfg_ff.max_iterations <= MAX_ITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   efi_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .fractal_kind (cfg_ff.fractal_kind),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .status       (status)
   );

   // arithmetic, point state and output register
   efi_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .cfg                    (cfg_ff),
      .req_pixel_x            (req_pixel_x),
      .req_pixel_y            (req_pixel_y),
      .rsp_iterations         (rsp_iterations),
      .rsp_final_magnitude_sq (rsp_final_magnitude_sq)
   );

   // a taken request always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted item did not start processing");

   // multiplier results only show up while an item is in flight
   assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> !req_ready)
      else $error("multiplier finished while idle");

   // the output register is never overwritten while it holds an untaken item
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");

   // julia orbits are never cut short by the period check
   assert property (@(posedge clock) disable iff (reset)
      cmd.set_periodic |-> (cfg_ff.fractal_kind != KIND_JULIA))
      else $error("period check fired for julia");

endmodule

`default_nettype wire
